FILE: src/kmeans_clustering_defines.svh
// Assertion helpers used by the checker file
`ifndef KMEANS_CLUSTERING_DEFINES_SVH
`define KMEANS_CLUSTERING_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define KMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause
`define KMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/kmc_pkg.sv
package kmc_pkg;

  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 8;
  localparam int MEAN_W    = 25;
  localparam int DIFF_W    = 26;
  localparam int DIST_W    = 52;

  // Input kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_ASSIGN = 2'd1;
  localparam logic [1:0] KIND_COUNT  = 2'd2;

  // Result kinds
  localparam logic [1:0] RES_DONE   = 2'd0;
  localparam logic [1:0] RES_ASSIGN = 2'd1;
  localparam logic [1:0] RES_COUNT  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_OK  = 2'd0;
  localparam logic [1:0] ERR_FEW = 2'd1;
  localparam logic [1:0] ERR_OVF = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_CLUSTERS = 2'd0;
  localparam logic [1:0] REG_ITER     = 2'd1;
  localparam logic [1:0] REG_DIMS     = 2'd2;

  localparam logic [4:0] CLUSTERS_RST = 5'd2;
  localparam logic [7:0] ITER_RST     = 8'd100;
  localparam logic [2:0] DIMS_RST     = 3'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] coord_0;
    logic signed [15:0] coord_1;
    logic signed [15:0] coord_2;
    logic signed [15:0] coord_3;
    logic               last_point;
    logic [9:0]         index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [9:0]  item_index;
    logic [10:0] value;
    logic [1:0]  error_code;
  } out_item_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic       clear;
    logic       acc_en;
    logic       mean_init;
    logic       mean_we;
    logic [1:0] mean_dim;
    logic [2:0] dims;
  } kmc_ctl_t;

endpackage

FILE: src/kmc_ram.sv
module kmc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/kmc_div.sv
module kmc_div #(
  parameter int SUM_W = 26,
  parameter int CNT_W = 11
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [SUM_W-1:0]           num,
  input  logic [CNT_W-1:0]                  den,
  output logic                              done,
  output logic signed [kmc_pkg::MEAN_W-1:0] quot
);

  import kmc_pkg::*;

  localparam int NUM_W = SUM_W + FRAC_BITS;
  localparam int C_W   = $clog2(NUM_W + 1);

  logic             busy;
  logic [C_W-1:0]   cnt;
  logic [NUM_W-1:0] q;
  logic [CNT_W:0]   rem;
  logic [CNT_W:0]   rem_sh;
  logic [CNT_W-1:0] den_r;
  logic             neg;
  logic             ge;
  logic [SUM_W-1:0] mag;

  assign mag    = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
  assign rem_sh = {rem[CNT_W-1:0], q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  // Sequence one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= C_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - C_W'(1);
        if (cnt == C_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring shift-subtract on the magnitude
  always_ff @(posedge clk) begin
    if (start) begin
      q     <= {mag, {FRAC_BITS{1'b0}}};
      rem   <= '0;
      den_r <= den;
      neg   <= num[SUM_W-1];
    end else if (busy) begin
      q   <= {q[NUM_W-2:0], ge};
      rem <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
    end
  end

  // Truncate toward zero: restore the sign
  assign quot = MEAN_W'(neg ? (~q + NUM_W'(1)) : q);

endmodule

FILE: src/kmc_cell.sv
module kmc_cell #(
  parameter int CELL_ID  = 0,
  parameter int MAX_DIMS = 4,
  parameter int CL_W     = 4,
  parameter int K_W      = 5,
  parameter int PA_W     = 10,
  parameter int SUM_W    = 26,
  parameter int CNT_W    = 11
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  kmc_pkg::kmc_ctl_t                      ctl,
  input  logic [K_W-1:0]                         k,
  input  logic [CL_W-1:0]                        acc_idx,
  input  logic [MAX_DIMS*kmc_pkg::COORD_W-1:0]   acc_pt,
  input  logic [CL_W-1:0]                        mean_sel,
  input  logic signed [kmc_pkg::MEAN_W-1:0]      mean_wdata,
  input  logic [MAX_DIMS*kmc_pkg::COORD_W-1:0]   init_pt,
  input  logic                                   in_v,
  input  logic [MAX_DIMS*kmc_pkg::COORD_W-1:0]   in_pt,
  input  logic [PA_W-1:0]                        in_pidx,
  input  logic [kmc_pkg::DIST_W-1:0]             in_bd,
  input  logic [CL_W-1:0]                        in_bi,
  output logic                                   out_v,
  output logic [MAX_DIMS*kmc_pkg::COORD_W-1:0]   out_pt,
  output logic [PA_W-1:0]                        out_pidx,
  output logic [kmc_pkg::DIST_W-1:0]             out_bd,
  output logic [CL_W-1:0]                        out_bi,
  output logic [CNT_W-1:0]                       count,
  output logic [MAX_DIMS*SUM_W-1:0]              sum
);

  import kmc_pkg::*;

  localparam logic [CL_W-1:0] MY_ID = CL_W'(CELL_ID);
  localparam int PT_W = MAX_DIMS * COORD_W;

  logic signed [MEAN_W-1:0] mean [MAX_DIMS];
  logic signed [SUM_W-1:0]  acc  [MAX_DIMS];
  logic [DIST_W-1:0]        sq   [MAX_DIMS];
  logic [DIST_W-1:0]        s1_sq [MAX_DIMS];
  logic                     s1_v;
  logic [PT_W-1:0]          s1_pt;
  logic [PA_W-1:0]          s1_pidx;
  logic [DIST_W-1:0]        s1_bd;
  logic [CL_W-1:0]          s1_bi;
  logic [DIST_W-1:0]        dist_sum;
  logic                     active;
  logic                     take;

  assign active = CELL_ID < int'(k);

  // Square the per-coordinate offsets from this mean
  always_comb begin
    logic signed [COORD_W-1:0]  cv;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [2*DIFF_W-1:0] prod;
    for (int d = 0; d < MAX_DIMS; d++) begin
      cv    = in_pt[d*COORD_W +: COORD_W];
      diff  = $signed({{(DIFF_W-COORD_W-FRAC_BITS){cv[COORD_W-1]}}, cv, {FRAC_BITS{1'b0}}})
            - $signed({mean[d][MEAN_W-1], mean[d]});
      prod  = diff * diff;
      sq[d] = (d < int'(ctl.dims)) ? DIST_W'(prod) : '0;
    end
  end

  // Add the squares and compare with the best so far
  always_comb begin
    dist_sum = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      dist_sum = dist_sum + s1_sq[d];
    end
  end

  // Ties go to the higher index, so the later cell wins on equal
  assign take = (CELL_ID == 0) || (active && (dist_sum <= s1_bd));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      s1_v  <= in_v;
      out_v <= s1_v;
    end
  end

  // Advance the point and the running best two stages per cell
  always_ff @(posedge clk) begin
    s1_pt    <= in_pt;
    s1_pidx  <= in_pidx;
    s1_bd    <= in_bd;
    s1_bi    <= in_bi;
    s1_sq    <= sq;
    out_pt   <= s1_pt;
    out_pidx <= s1_pidx;
    out_bd   <= take ? dist_sum : s1_bd;
    out_bi   <= take ? MY_ID : s1_bi;
  end

  // Accumulate members of this cluster
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      count <= '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
        acc[d] <= '0;
      end
    end else if (ctl.acc_en && (acc_idx == MY_ID)) begin
      count <= count + CNT_W'(1);
      for (int d = 0; d < MAX_DIMS; d++) begin
        acc[d] <= acc[d] + SUM_W'($signed(acc_pt[d*COORD_W +: COORD_W]));
      end
    end
  end

  // Load or update the mean
  always_ff @(posedge clk) begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (ctl.mean_init && (mean_sel == MY_ID)) begin
        mean[d] <= MEAN_W'($signed({init_pt[d*COORD_W +: COORD_W], {FRAC_BITS{1'b0}}}));
      end else if (ctl.mean_we && (mean_sel == MY_ID) && (int'(ctl.mean_dim) == d)) begin
        mean[d] <= mean_wdata;
      end
    end
  end

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      sum[d*SUM_W +: SUM_W] = acc[d];
    end
  end

endmodule

FILE: src/kmeans_clustering.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | in_item_t: kind, coords, last_point, index
// out     | output    | out_valid/out_stall | out_item_t: kind, index, value, error
// cfg     | input     | psel/penable/pready | 32-bit register write and read
//
// A load without last_point gives no result; a count readout is answered from the
// idle state, and an assignment readout first passes through a read-wait state.
// A run streams the point memory through the cell chain and updates each mean
// coordinate with the shared divider. With fewer points than clusters a run zeros
// the stored assignments and reports ERR_FEW.
// Reset is synchronous; the input stalls while the sequencer is not idle or a result waits.
module kmeans_clustering #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  kmc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kmc_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import kmc_pkg::*;

  localparam int PA_W    = $clog2(MAX_POINTS);
  localparam int PL_W    = $clog2(MAX_POINTS + 1);
  localparam int CL_W    = $clog2(MAX_CLUSTERS);
  localparam int K_W     = $clog2(MAX_CLUSTERS + 1);
  localparam int SUM_W   = COORD_W + PA_W;
  localparam int CNT_W   = PL_W;
  localparam int PT_W    = COORD_W * MAX_DIMS;
  localparam int DRAIN_N = 2 * MAX_CLUSTERS + 2;
  localparam int DR_W    = $clog2(DRAIN_N + 1);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b000000000001,
    S_RDWAIT    = 12'b000000000010,
    S_START     = 12'b000000000100,
    S_FILL0     = 12'b000000001000,
    S_INIT_RD   = 12'b000000010000,
    S_INIT_WR   = 12'b000000100000,
    S_PASS      = 12'b000001000000,
    S_STREAM    = 12'b000010000000,
    S_DRAIN     = 12'b000100000000,
    S_DIV_START = 12'b001000000000,
    S_DIV_WAIT  = 12'b010000000000,
    S_FINISH    = 12'b100000000000
  } state_t;

  state_t            state;
  logic [4:0]        cluster_count;
  logic [7:0]        iteration_limit;
  logic [2:0]        dims_in_use;
  logic [PL_W-1:0]   pl;
  logic              ovf;
  logic              set_closed;
  logic [1:0]        err;
  logic [PA_W-1:0]   p;
  logic [CL_W-1:0]   c;
  logic [1:0]        d;
  logic [7:0]        pass;
  logic [DR_W-1:0]   drain;
  logic [9:0]        idx_r;
  logic              stream_v;
  logic [PA_W-1:0]   stream_pidx;

  logic [K_W-1:0]    k_eff;
  logic [7:0]        passes_eff;
  logic [2:0]        dims_eff;
  logic              in_acc;
  logic [PL_W-1:0]   base;
  logic              room;
  logic              c_last;
  logic              d_last;
  logic              p_last;
  logic              pass_last;
  logic [PT_W-1:0]   pt_in;
  logic              pt_we;
  logic [PA_W-1:0]   pt_raddr;
  logic [PT_W-1:0]   pt_rdata;
  logic              asg_we;
  logic [PA_W-1:0]   asg_waddr;
  logic [CL_W-1:0]   asg_wdata;
  logic [CL_W-1:0]   asg_rdata;
  logic [CL_W-1:0]   rd_sel;
  logic [CNT_W-1:0]  count_sel;
  logic [SUM_W-1:0]  sum_sel;
  logic              div_start;
  logic              div_done;
  logic signed [MEAN_W-1:0] div_quot;
  kmc_ctl_t          ctl;

  logic              ch_v    [MAX_CLUSTERS+1];
  logic [PT_W-1:0]   ch_pt   [MAX_CLUSTERS+1];
  logic [PA_W-1:0]   ch_pidx [MAX_CLUSTERS+1];
  logic [DIST_W-1:0] ch_bd   [MAX_CLUSTERS+1];
  logic [CL_W-1:0]   ch_bi   [MAX_CLUSTERS+1];
  logic [CNT_W-1:0]  count_all [MAX_CLUSTERS];
  logic [MAX_DIMS*SUM_W-1:0] sum_all [MAX_CLUSTERS];

  // Clamp the configuration to its working range
  always_comb begin
    if (cluster_count == 5'd0) begin
      k_eff = K_W'(1);
    end else if (int'(cluster_count) > MAX_CLUSTERS) begin
      k_eff = K_W'(MAX_CLUSTERS);
    end else begin
      k_eff = K_W'(cluster_count);
    end
    passes_eff = (iteration_limit == 8'd0) ? 8'd1 : iteration_limit;
    if (dims_in_use == 3'd0) begin
      dims_eff = 3'd1;
    end else if (int'(dims_in_use) > MAX_DIMS) begin
      dims_eff = 3'(MAX_DIMS);
    end else begin
      dims_eff = dims_in_use;
    end
  end

  assign in_stall  = (state != S_IDLE) || out_valid;
  assign in_acc    = in_valid && !in_stall;
  assign base      = set_closed ? '0 : pl;
  assign room      = int'(base) < MAX_POINTS;
  assign c_last    = (int'(c) + 1) == int'(k_eff);
  assign d_last    = (int'(d) + 1) == int'(dims_eff);
  assign p_last    = (int'(p) + 1) == int'(pl);
  assign pass_last = (int'(pass) + 1) == int'(passes_eff);

  // Pack the used coordinates of the incoming point
  always_comb begin
    logic [3:0][COORD_W-1:0] all;
    all   = {in_data.coord_3, in_data.coord_2, in_data.coord_1, in_data.coord_0};
    pt_in = all[MAX_DIMS-1:0];
  end

  assign pt_we    = in_acc && (in_data.kind == KIND_LOAD) && room;
  assign pt_raddr = (state == S_INIT_RD) ? PA_W'(pl - PL_W'(c) - PL_W'(1)) : p;

  kmc_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (PA_W'(base)),
    .wdata (pt_in),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  // Write assignments from the chain end, or zero them when too few points
  assign asg_we    = ch_v[MAX_CLUSTERS] || (state == S_FILL0);
  assign asg_waddr = ch_v[MAX_CLUSTERS] ? ch_pidx[MAX_CLUSTERS] : p;
  assign asg_wdata = ch_v[MAX_CLUSTERS] ? ch_bi[MAX_CLUSTERS] : '0;

  kmc_ram #(.WIDTH(CL_W), .DEPTH(MAX_POINTS)) u_asg_ram (
    .clk   (clk),
    .we    (asg_we),
    .waddr (asg_waddr),
    .wdata (asg_wdata),
    .raddr (PA_W'(in_data.index)),
    .rdata (asg_rdata)
  );

  // Broadcast control
  always_comb begin
    ctl.clear     = (state == S_START) || (state == S_PASS);
    ctl.acc_en    = ch_v[MAX_CLUSTERS];
    ctl.mean_init = (state == S_INIT_WR);
    ctl.mean_we   = div_done;
    ctl.mean_dim  = d;
    ctl.dims      = dims_eff;
  end

  // Feed the chain from the point memory
  assign ch_v[0]    = stream_v;
  assign ch_pt[0]   = pt_rdata;
  assign ch_pidx[0] = stream_pidx;
  assign ch_bd[0]   = '0;
  assign ch_bi[0]   = '0;

  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    kmc_cell #(
      .CELL_ID  (g),
      .MAX_DIMS (MAX_DIMS),
      .CL_W     (CL_W),
      .K_W      (K_W),
      .PA_W     (PA_W),
      .SUM_W    (SUM_W),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .k          (k_eff),
      .acc_idx    (ch_bi[MAX_CLUSTERS]),
      .acc_pt     (ch_pt[MAX_CLUSTERS]),
      .mean_sel   (c),
      .mean_wdata (div_quot),
      .init_pt    (pt_rdata),
      .in_v       (ch_v[g]),
      .in_pt      (ch_pt[g]),
      .in_pidx    (ch_pidx[g]),
      .in_bd      (ch_bd[g]),
      .in_bi      (ch_bi[g]),
      .out_v      (ch_v[g+1]),
      .out_pt     (ch_pt[g+1]),
      .out_pidx   (ch_pidx[g+1]),
      .out_bd     (ch_bd[g+1]),
      .out_bi     (ch_bi[g+1]),
      .count      (count_all[g]),
      .sum        (sum_all[g])
    );
  end

  // One cluster select serves both the count readout and the mean update
  assign rd_sel    = (state == S_IDLE) ? CL_W'(in_data.index) : c;
  assign count_sel = count_all[rd_sel];

  always_comb begin
    sum_sel = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (int'(d) == i) begin
        sum_sel = sum_all[rd_sel][i*SUM_W +: SUM_W];
      end
    end
  end

  assign div_start = (state == S_DIV_START) && (count_sel != '0);

  kmc_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ($signed(sum_sel)),
    .den   (count_sel),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Configuration port
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_CLUSTERS: prdata = {27'd0, cluster_count};
      REG_ITER:     prdata = {24'd0, iteration_limit};
      REG_DIMS:     prdata = {29'd0, dims_in_use};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count   <= CLUSTERS_RST;
      iteration_limit <= ITER_RST;
      dims_in_use     <= DIMS_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_CLUSTERS: cluster_count   <= pwdata[4:0];
        REG_ITER:     iteration_limit <= pwdata[7:0];
        REG_DIMS:     dims_in_use     <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Point index that travels with the stream, and the index of an accepted item
  always_ff @(posedge clk) begin
    stream_pidx <= p;
    if (in_acc) begin
      idx_r <= in_data.index;
    end
  end

  // Sequencer: loads, readouts and the clustering run
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pl         <= '0;
      ovf        <= 1'b0;
      set_closed <= 1'b0;
      err        <= ERR_OK;
      p          <= '0;
      c          <= '0;
      d          <= '0;
      pass       <= '0;
      drain      <= '0;
      stream_v   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      stream_v <= (state == S_STREAM);
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (in_data.kind)
              KIND_LOAD: begin
                set_closed <= in_data.last_point;
                if (room) begin
                  pl  <= base + PL_W'(1);
                  ovf <= set_closed ? 1'b0 : ovf;
                end else begin
                  pl  <= base;
                  ovf <= 1'b1;
                end
                if (in_data.last_point) begin
                  state <= S_START;
                end
              end
              KIND_ASSIGN: begin
                if (int'(in_data.index) < MAX_POINTS) begin
                  state <= S_RDWAIT;
                end else begin
                  out_valid <= 1'b1;
                  out_data  <= {RES_ASSIGN, in_data.index, 11'd0, ERR_OK};
                end
              end
              KIND_COUNT: begin
                out_valid <= 1'b1;
                out_data  <= {RES_COUNT, in_data.index,
                              (int'(in_data.index) < MAX_CLUSTERS) ? 11'(count_sel) : 11'd0,
                              ERR_OK};
              end
              default: ;
            endcase
          end
        end
        S_RDWAIT: begin
          out_valid <= 1'b1;
          out_data  <= {RES_ASSIGN, idx_r, 11'(asg_rdata), ERR_OK};
          state     <= S_IDLE;
        end
        S_START: begin
          p <= '0;
          c <= '0;
          if (int'(pl) < int'(k_eff)) begin
            err   <= ERR_FEW;
            state <= S_FILL0;
          end else begin
            err   <= ovf ? ERR_OVF : ERR_OK;
            state <= S_INIT_RD;
          end
        end
        S_FILL0: begin
          if (p_last) begin
            state <= S_FINISH;
          end else begin
            p <= p + PA_W'(1);
          end
        end
        S_INIT_RD: begin
          state <= S_INIT_WR;
        end
        S_INIT_WR: begin
          if (c_last) begin
            c     <= '0;
            pass  <= '0;
            state <= S_PASS;
          end else begin
            c     <= c + CL_W'(1);
            state <= S_INIT_RD;
          end
        end
        S_PASS: begin
          p     <= '0;
          state <= S_STREAM;
        end
        S_STREAM: begin
          if (p_last) begin
            drain <= DR_W'(DRAIN_N);
            state <= S_DRAIN;
          end else begin
            p <= p + PA_W'(1);
          end
        end
        S_DRAIN: begin
          if (drain == '0) begin
            c     <= '0;
            d     <= '0;
            state <= S_DIV_START;
          end else begin
            drain <= drain - DR_W'(1);
          end
        end
        S_DIV_START: begin
          if (count_sel != '0) begin
            state <= S_DIV_WAIT;
          end else if (!c_last) begin
            // Empty cluster keeps its mean
            c <= c + CL_W'(1);
            d <= '0;
          end else if (pass_last) begin
            state <= S_FINISH;
          end else begin
            pass  <= pass + 8'd1;
            state <= S_PASS;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (!d_last) begin
              d     <= d + 2'd1;
              state <= S_DIV_START;
            end else if (!c_last) begin
              c     <= c + CL_W'(1);
              d     <= '0;
              state <= S_DIV_START;
            end else if (pass_last) begin
              state <= S_FINISH;
            end else begin
              pass  <= pass + 8'd1;
              state <= S_PASS;
            end
          end
        end
        S_FINISH: begin
          out_valid <= 1'b1;
          out_data  <= {RES_DONE, 10'd0, 11'(pl), err};
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/kmc_checker.sv
`include "kmeans_clustering_defines.svh"

module kmc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input kmc_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input kmc_pkg::out_item_t out_data
);

  import kmc_pkg::*;

  // A waiting result holds until transfer
  `KMC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // No new input while a result waits
  `KMC_ASSERT_NOW(a_in_blocked, out_valid, in_stall, "input taken while a result waits")

  // A count readout answers in the next cycle
  `KMC_ASSERT_NEXT(a_count_next, in_valid && !in_stall && in_data.kind == KIND_COUNT, out_valid && out_data.result_kind == RES_COUNT, "count readout late")

  // Readouts carry no error
  `KMC_ASSERT_NOW(a_read_ok, out_valid && out_data.result_kind != RES_DONE, out_data.error_code == ERR_OK, "readout with error")

endmodule

bind kmeans_clustering kmc_checker u_kmc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: tb/kmeans_clustering_tb.sv
module kmeans_clustering_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kmc_pkg::*;

  localparam int NUM_POINTS   = 1024;
  localparam int NUM_CLUSTERS = 16;
  localparam int NUM_DIMS     = 4;
  localparam int RANDOM_ITEMS = 740;
  localparam int SETTLE       = 60;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  kmeans_clustering i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow of the clustering engine
  logic [4:0]         k_reg;
  logic [7:0]         pass_reg;
  logic [2:0]         dims_reg;
  logic signed [15:0] point_mem [NUM_POINTS][NUM_DIMS];
  logic [3:0]         assign_mem [NUM_POINTS];
  longint             mean_mem [NUM_CLUSTERS][NUM_DIMS];
  longint             sum_mem [NUM_CLUSTERS][NUM_DIMS];
  int unsigned        member_cnt [NUM_CLUSTERS];
  int unsigned        pts_loaded;
  bit                 set_done;
  bit                 store_ovf;
  int unsigned        assigned_hi;

  out_item_t expected_results[$];
  int        mismatches;
  int        items_sent;
  bit        count_items;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  stim_row_t directed_rows[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned sq_dist(int p, int c, int dims);
    longint unsigned acc;
    longint          diff;
    acc = 0;
    for (int d = 0; d < dims; d++) begin
      diff = longint'(point_mem[p][d]) * 256 - mean_mem[c][d];
      if (diff < 0) diff = -diff;
      acc += longint'(diff) * longint'(diff);
    end
    return acc;
  endfunction

  // Run the Lloyd passes over the stored set and return the error code
  function automatic logic [1:0] run_lloyd();
    int unsigned     n, k, passes, dims, best;
    longint unsigned bd, dc;
    n = pts_loaded;
    k = (k_reg < 1) ? 1 : (k_reg > NUM_CLUSTERS) ? NUM_CLUSTERS : k_reg;
    passes = (pass_reg < 1) ? 1 : pass_reg;
    dims = (dims_reg < 1) ? 1 : (dims_reg > NUM_DIMS) ? NUM_DIMS : dims_reg;
    if (n > assigned_hi) assigned_hi = n;
    for (int c = 0; c < NUM_CLUSTERS; c++) begin
      member_cnt[c] = 0;
      for (int d = 0; d < NUM_DIMS; d++) sum_mem[c][d] = 0;
    end
    if (n < k) begin
      for (int p = 0; p < n; p++) assign_mem[p] = '0;
      return ERR_FEW;
    end
    for (int c = 0; c < k; c++)
      for (int d = 0; d < NUM_DIMS; d++)
        mean_mem[c][d] = longint'(point_mem[n - 1 - c][d]) * 256;
    for (int it = 0; it < passes; it++) begin
      for (int c = 0; c < NUM_CLUSTERS; c++) begin
        member_cnt[c] = 0;
        for (int d = 0; d < NUM_DIMS; d++) sum_mem[c][d] = 0;
      end
      for (int p = 0; p < n; p++) begin
        best = 0;
        bd = sq_dist(p, 0, dims);
        // ties go to the higher cluster
        for (int c = 1; c < k; c++) begin
          dc = sq_dist(p, c, dims);
          if (dc <= bd) begin
            bd = dc;
            best = c;
          end
        end
        assign_mem[p] = best[3:0];
        member_cnt[best]++;
        for (int d = 0; d < dims; d++) sum_mem[best][d] += point_mem[p][d];
      end
      // empty clusters keep their mean
      for (int c = 0; c < k; c++) begin
        if (member_cnt[c] != 0)
          for (int d = 0; d < dims; d++)
            mean_mem[c][d] = (sum_mem[c][d] * 256) / longint'(member_cnt[c]);
      end
    end
    return store_ovf ? ERR_OVF : ERR_OK;
  endfunction

  function automatic bit predict_item(in_item_t it, output out_item_t r);
    r = '0;
    case (it.kind)
      KIND_LOAD: begin
        if (set_done) begin
          pts_loaded = 0;
          store_ovf = 1'b0;
          set_done = 1'b0;
        end
        if (pts_loaded < NUM_POINTS) begin
          point_mem[pts_loaded][0] = it.coord_0;
          point_mem[pts_loaded][1] = it.coord_1;
          point_mem[pts_loaded][2] = it.coord_2;
          point_mem[pts_loaded][3] = it.coord_3;
          pts_loaded++;
        end else begin
          store_ovf = 1'b1;
        end
        if (!it.last_point) return 1'b0;
        r.error_code = run_lloyd();
        set_done = 1'b1;
        r.result_kind = RES_DONE;
        r.value = pts_loaded[10:0];
        return 1'b1;
      end
      KIND_ASSIGN: begin
        r.result_kind = RES_ASSIGN;
        r.item_index = it.index;
        r.value = {7'd0, assign_mem[it.index]};
        return 1'b1;
      end
      KIND_COUNT: begin
        r.result_kind = RES_COUNT;
        r.item_index = it.index;
        r.value = (it.index < NUM_CLUSTERS) ? member_cnt[it.index][10:0] : '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic in_item_t mk_in(logic [1:0] kind, int c0, int c1, int c2, int c3,
                                     bit last, int idx);
    in_item_t it;
    it.kind = kind;
    it.coord_0 = c0[15:0];
    it.coord_1 = c1[15:0];
    it.coord_2 = c2[15:0];
    it.coord_3 = c3[15:0];
    it.last_point = last;
    it.index = idx[9:0];
    return it;
  endfunction

  function automatic out_item_t mk_out(logic [1:0] kind, int idx, int val, logic [1:0] err);
    out_item_t r;
    r.result_kind = kind;
    r.item_index = idx[9:0];
    r.value = val[10:0];
    r.error_code = err;
    return r;
  endfunction

  function automatic void add_row(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  // Present one item after a random gap, hold it until transfer, record its result
  task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    int        r, gap;
    out_item_t pred;
    r = $urandom_range(0, 99);
    gap = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_item(it, pred)) expected_results.push_back(typed ? want : pred);
    if (count_items && it.kind != 2'd3) items_sent++;
  endtask

  // Drop valid and wait until every result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] regno, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regno, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (regno)
      REG_CLUSTERS: k_reg = data[4:0];
      REG_ITER:     pass_reg = data[7:0];
      REG_DIMS:     dims_reg = data[2:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int k, int passes, int dims);
    drain();
    reg_write(REG_CLUSTERS, k);
    reg_write(REG_ITER, passes);
    reg_write(REG_DIMS, dims);
  endtask

  function automatic int pick_coord(int mode, int center);
    case (mode)
      0: return $urandom_range(0, 65535);
      1: return center + $urandom_range(0, 200) - 100;
      default: return $urandom_range(0, 2) - 1;
    endcase
  endfunction

  // Load one set of points with random content, then read some results back
  task automatic run_set(int n, int noise_pct);
    int mode, pick;
    int ctr [4][4];
    mode = $urandom_range(0, 2);
    for (int g = 0; g < 4; g++)
      for (int d = 0; d < 4; d++) ctr[g][d] = $urandom_range(0, 60000) - 30000;
    for (int p = 0; p < n; p++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        if (assigned_hi > 0 && $urandom_range(0, 1))
          send_item(mk_in(KIND_ASSIGN, $urandom, $urandom, $urandom, $urandom,
                          $urandom_range(0, 1), $urandom_range(0, assigned_hi - 1)));
        else
          send_item(mk_in(2'd3, $urandom, $urandom, $urandom, $urandom,
                          $urandom_range(0, 1), $urandom));
      end
      pick = $urandom_range(0, 3);
      send_item(mk_in(KIND_LOAD, pick_coord(mode, ctr[pick][0]),
                      pick_coord(mode, ctr[pick][1]), pick_coord(mode, ctr[pick][2]),
                      pick_coord(mode, ctr[pick][3]), p == n - 1, $urandom));
    end
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 1))
        send_item(mk_in(KIND_ASSIGN, $urandom, $urandom, $urandom, $urandom,
                        $urandom_range(0, 1), $urandom_range(0, assigned_hi - 1)));
      else
        send_item(mk_in(KIND_COUNT, $urandom, $urandom, $urandom, $urandom,
                        $urandom_range(0, 1),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, 17)));
    end
  endtask

  // Receiver: random stalls, mostly short, a few long, with quiet stretches
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3) : $urandom_range(10, 60);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (($urandom_range(0, 19) == 0) ? $urandom_range(50, 200)
                                           : $urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d index %0d value %0d err %0d",
                   out_data.result_kind, out_data.item_index, out_data.value,
                   out_data.error_code);
      end else begin
        want = expected_results.pop_front();
        if (out_data.result_kind !== want.result_kind ||
            out_data.item_index !== want.item_index ||
            out_data.value !== want.value ||
            out_data.error_code !== want.error_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind %0d index %0d value %0d err %0d, got %0d %0d %0d %0d",
                     want.result_kind, want.item_index, want.value, want.error_code,
                     out_data.result_kind, out_data.item_index, out_data.value,
                     out_data.error_code);
        end
      end
    end
  end

  initial begin
    #1_000_000_000;
    $display("kmeans_clustering_tb: FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    k_reg = CLUSTERS_RST;
    pass_reg = ITER_RST;
    dims_reg = DIMS_RST;
    pts_loaded = 0;
    set_done = 1'b0;
    store_ovf = 1'b0;
    assigned_hi = 0;
    mismatches = 0;
    items_sent = 0;
    count_items = 1'b0;
    for (int c = 0; c < NUM_CLUSTERS; c++) member_cnt[c] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty counts, ignored kind, too few points, extremes, ties
    add_row(mk_in(KIND_COUNT, 0, 0, 0, 0, 0, 0), 1, mk_out(RES_COUNT, 0, 0, ERR_OK));
    add_row(mk_in(KIND_COUNT, -1, -1, -1, -1, 1, 1023), 1,
            mk_out(RES_COUNT, 1023, 0, ERR_OK));
    add_row(mk_in(2'd3, -1, -1, -1, -1, 1, 1023));
    add_row(mk_in(KIND_LOAD, 7, 7, 7, 7, 1, 0), 1, mk_out(RES_DONE, 0, 1, ERR_FEW));
    add_row(mk_in(KIND_ASSIGN, 0, 0, 0, 0, 0, 0), 1, mk_out(RES_ASSIGN, 0, 0, ERR_OK));
    add_row(mk_in(KIND_COUNT, 0, 0, 0, 0, 0, 1), 1, mk_out(RES_COUNT, 1, 0, ERR_OK));
    add_row(mk_in(KIND_LOAD, 32767, -32768, 32767, -32768, 0, 0));
    add_row(mk_in(KIND_LOAD, -32768, 32767, -32768, 32767, 0, 0));
    add_row(mk_in(KIND_LOAD, 0, 0, 0, 0, 0, 0));
    add_row(mk_in(KIND_LOAD, 32767, 32767, 0, 0, 1, 0));
    for (int i = 0; i < 4; i++) add_row(mk_in(KIND_ASSIGN, 0, 0, 0, 0, 0, i));
    add_row(mk_in(KIND_COUNT, 0, 0, 0, 0, 0, 0));
    add_row(mk_in(KIND_COUNT, 0, 0, 0, 0, 0, 1));
    add_row(mk_in(KIND_LOAD, 5, 5, 5, 5, 0, 0));
    add_row(mk_in(KIND_LOAD, 5, 5, 5, 5, 1, 0));
    add_row(mk_in(KIND_ASSIGN, 0, 0, 0, 0, 0, 0));
    add_row(mk_in(KIND_ASSIGN, 0, 0, 0, 0, 0, 1));
    add_row(mk_in(KIND_COUNT, 0, 0, 0, 0, 0, 1));
    add_row(mk_in(KIND_COUNT, 0, 0, 0, 0, 0, 15));
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // Register extremes, including out-of-range values that clamp
    set_config(16, 1, 4);
    run_set(24, 0);
    set_config(1, 255, 1);
    run_set(12, 0);
    set_config(31, 2, 7);
    run_set(20, 5);
    set_config(0, 0, 0);
    run_set(6, 5);

    // Overflow the point store; the run still covers the stored points
    set_config(2, 1, 1);
    for (int p = 0; p < NUM_POINTS + 2; p++)
      send_item(mk_in(KIND_LOAD, $urandom, $urandom, $urandom, $urandom,
                      p == NUM_POINTS + 1, $urandom));
    send_item(mk_in(KIND_ASSIGN, 0, 0, 0, 0, 0, 1023));
    send_item(mk_in(KIND_COUNT, 0, 0, 0, 0, 0, 1));

    // Random sets with occasional reconfiguration
    count_items = 1'b1;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 35) begin
        automatic int k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(1, 6);
        automatic int passes = ($urandom_range(0, 14) == 0) ? 100 : $urandom_range(0, 6);
        set_config(k, passes, $urandom_range(0, 7));
      end else if ($urandom_range(0, 9) == 0) begin
        drain();
      end
      run_set(($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(2, 24), 8);
    end

    drain();
    if (mismatches == 0) begin
      $display("kmeans_clustering_tb: PASS");
    end else begin
      $display("kmeans_clustering_tb: FAIL");
    end
    $finish;
  end

endmodule
